// File: rtl/fclv_pkg.sv
package fclv_pkg;

	localparam logic [15:0] CK_POLY         = 16'h8005;
	localparam logic [15:0] CK_TOP          = 16'h8000;
	localparam logic [15:0] MIN_FRAME       = 16'd4;
	localparam logic [15:0] MAX_FRAME_RESET = 16'd1400;
	localparam logic [15:0] COUNT_SAT       = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_LONG  = 3'd2,
		ST_LEN   = 3'd3,
		ST_CK    = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        frame_ok;
		status_t     status;
		logic [15:0] frame_bytes;
		logic [15:0] computed_checksum;
	} result_t;

	// shift-and-poly step, then fold in {prev, b}
	function automatic logic [15:0] fold_byte(input logic [15:0] ck, input logic [7:0] prev,
		input logic [7:0] b);
		logic [15:0] v;
		begin
			v = {ck[14:0], 1'b0};
			if ((ck & CK_TOP) != 16'd0) begin
				v = v ^ CK_POLY;
			end
			fold_byte = v ^ {prev, b};
		end
	endfunction

endpackage

// File: rtl/fclv_in_stage.sv
module fclv_in_stage
	import fclv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic vld_s1;

	assign in_ready = !vld_s1 || advance;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data_byte <= data_byte;
			item_s1.last_byte <= last_byte;
		end
	end

	// a held byte leaves only by moving into the frame state
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(item_s1))
		else $error("input stage lost a byte");

endmodule

// File: rtl/fclv_frame_core.sv
module fclv_frame_core
	import fclv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  item_t       item,
	input  logic [15:0] max_frame,
	output result_t     res
);

	logic [15:0] count_q;
	logic [15:0] ck_q;
	logic [7:0]  prev_q;
	logic [15:0] ck_field_q;
	logic [15:0] len_field_q;

	logic [15:0] count_nx;
	logic [15:0] ck_nx;
	logic [7:0]  prev_nx;
	logic [15:0] ck_field_nx;
	logic [15:0] len_field_nx;
	status_t     st;

	always_comb begin
		ck_field_nx  = ck_field_q;
		len_field_nx = len_field_q;
		ck_nx        = ck_q;
		prev_nx      = prev_q;
		if (count_q == 16'd0) begin
			ck_field_nx[7:0] = item.data_byte;
		end else if (count_q == 16'd1) begin
			ck_field_nx[15:8] = item.data_byte;
		end else begin
			if (count_q == 16'd2) begin
				len_field_nx[7:0] = item.data_byte;
			end else if (count_q == 16'd3) begin
				len_field_nx[15:8] = item.data_byte;
			end
			ck_nx   = fold_byte(ck_q, prev_q, item.data_byte);
			prev_nx = item.data_byte;
		end
		count_nx = (count_q == COUNT_SAT) ? count_q : count_q + 16'd1;
	end

	always_comb begin
		priority if (count_nx < MIN_FRAME) begin
			st = ST_SHORT;
		end else if (count_nx > max_frame) begin
			st = ST_LONG;
		end else if (count_nx != len_field_nx) begin
			st = ST_LEN;
		end else if (ck_field_nx != ck_nx) begin
			st = ST_CK;
		end else begin
			st = ST_OK;
		end
		res.frame_ok          = (st == ST_OK);
		res.status            = st;
		res.frame_bytes       = count_nx;
		res.computed_checksum = ck_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ck_q        <= '0;
			prev_q      <= '0;
			ck_field_q  <= '0;
			len_field_q <= '0;
		end else if (take) begin
			if (item.last_byte) begin
				count_q     <= '0;
				ck_q        <= '0;
				prev_q      <= '0;
				ck_field_q  <= '0;
				len_field_q <= '0;
			end else begin
				count_q     <= count_nx;
				ck_q        <= ck_nx;
				prev_q      <= prev_nx;
				ck_field_q  <= ck_field_nx;
				len_field_q <= len_field_nx;
			end
		end
	end

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.last_byte |=> count_q == 16'd0 && ck_q == 16'd0)
		else $error("frame state not cleared after last byte");

	a_ckfield: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item.last_byte && count_q >= 16'd2 |=> $stable(ck_field_q))
		else $error("checksum field changed past byte one");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(count_q))
		else $error("byte count moved without a byte");

endmodule

// File: rtl/fclv_out_stage.sv
module fclv_out_stage
	import fclv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_q
);

	logic out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.frame_ok == (res_q.status == ST_OK))
		else $error("frame_ok disagrees with status");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

// File: rtl/frame_length_checksum_validator.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | data_byte[7:0], last_byte
// out     | output    | out_valid / out_ready | frame_ok, status[2:0], frame_bytes[15:0],
//         |           |                       | computed_checksum[15:0]
// cfg     | input     | cfg_valid / cfg_ready | cfg_data[15:0] (max_frame_bytes)
//
// One byte per cycle sustained unless a last byte waits on a stalled result. Each byte
// moves from the input register into the frame state, loading the result if it is last.
// The checksum fold and the status compare sit between the input register and the
// result register; nothing iterates.
// Reset clears the frame state and sets max_frame_bytes to 1400; cfg_ready is always high.
// A stalled result stalls only a last byte; other bytes keep flowing into the frame state.
module frame_length_checksum_validator
	import fclv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic [2:0]  status,
	output logic [15:0] frame_bytes,
	output logic [15:0] computed_checksum,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	logic        load;
	logic [15:0] max_frame_q;
	result_t     res;
	result_t     res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_frame_q <= cfg_data;
		end
	end

	assign advance = valid_s1 && (!item_s1.last_byte || !out_valid || out_ready);
	assign load    = advance && item_s1.last_byte;

	fclv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fclv_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (advance),
		.item     (item_s1),
		.max_frame(max_frame_q),
		.res      (res)
	);

	fclv_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_q    (res_q)
	);

	assign frame_ok          = res_q.frame_ok;
	assign status            = res_q.status;
	assign frame_bytes       = res_q.frame_bytes;
	assign computed_checksum = res_q.computed_checksum;

endmodule

// File: tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fclv_pkg::*;

	typedef enum int {
		SHAPE_CLEAN,
		SHAPE_BAD_LENGTH,
		SHAPE_BAD_SUM,
		SHAPE_RAW
	} frame_shape_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        frame_ok;
	logic [2:0]  status;
	logic [15:0] frame_bytes;
	logic [15:0] computed_checksum;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// predictor copy of the register and the frame state
	logic [15:0] max_bytes_cfg = MAX_FRAME_RESET;
	logic [15:0] acc_count = '0;
	logic [15:0] acc_crc = '0;
	logic [7:0]  acc_prev = '0;
	logic [15:0] acc_ck_field = '0;
	logic [15:0] acc_len_field = '0;

	result_t pending_results[$];
	int      errors = 0;
	int      n_bytes = 0;
	int      n_results = 0;
	int      status_hits[5] = '{default: 0};
	int      cycles = 0;
	bit      in_quiet = 1'b0;
	bit      out_quiet = 1'b0;

	frame_length_checksum_validator i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.frame_ok          (frame_ok),
		.status            (status),
		.frame_bytes       (frame_bytes),
		.computed_checksum (computed_checksum),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("frame_length_checksum_validator: mismatch");
			$finish;
		end
	end

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] hi,
		input logic [7:0] lo);
		logic [15:0] shifted;
		shifted = {crc[14:0], 1'b0} ^ (crc[15] ? CK_POLY : 16'h0000);
		return shifted ^ {hi, lo};
	endfunction

	// fold one accepted byte into the predicted frame state
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		result_t r;
		status_t st;
		case (acc_count)
		16'd0: acc_ck_field[7:0] = b;
		16'd1: acc_ck_field[15:8] = b;
		default: begin
			if (acc_count == 16'd2)
				acc_len_field[7:0] = b;
			if (acc_count == 16'd3)
				acc_len_field[15:8] = b;
			acc_crc = crc_next(acc_crc, acc_prev, b);
			acc_prev = b;
		end
		endcase
		if (acc_count != COUNT_SAT)
			acc_count++;
		if (last) begin
			if (acc_count < MIN_FRAME)
				st = ST_SHORT;
			else if (acc_count > max_bytes_cfg)
				st = ST_LONG;
			else if (acc_count != acc_len_field)
				st = ST_LEN;
			else if (acc_ck_field != acc_crc)
				st = ST_CK;
			else
				st = ST_OK;
			r.frame_ok = (st == ST_OK);
			r.status = st;
			r.frame_bytes = acc_count;
			r.computed_checksum = acc_crc;
			pending_results.push_back(r);
			acc_count = '0;
			acc_crc = '0;
			acc_prev = '0;
			acc_ck_field = '0;
			acc_len_field = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		absorb_byte(b, last);
		n_bytes++;
	endtask

	// length and checksum fields are patched in unless the frame is raw or under four bytes
	task automatic push_frame(input int n, input frame_shape_t shape, input int fill = -1);
		logic [7:0]  q[$];
		logic [15:0] crc;
		logic [15:0] len;
		for (int i = 0; i < n; i++)
			q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		if (shape != SHAPE_RAW && n >= 4) begin
			len = (n > 65535) ? 16'hFFFF : 16'(n);
			if (shape == SHAPE_BAD_LENGTH)
				len ^= 16'($urandom_range(1, 65535));
			q[2] = len[7:0];
			q[3] = len[15:8];
			crc = '0;
			for (int i = 2; i < n; i++)
				crc = crc_next(crc, (i == 2) ? 8'h00 : q[i - 1], q[i]);
			if (shape == SHAPE_BAD_SUM)
				crc ^= 16'($urandom_range(1, 65535));
			q[0] = crc[7:0];
			q[1] = crc[15:8];
		end
		for (int i = 0; i < n; i++)
			send_byte(q[i], i == n - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max(input logic [15:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_bytes_cfg = value;
	endtask

	task automatic test_short_frames();
		push_frame(1, SHAPE_RAW, 8'hFF);
		push_frame(2, SHAPE_RAW, 8'h00);
		push_frame(3, SHAPE_RAW, 8'hFF);
		push_frame(3, SHAPE_RAW);
	endtask

	task automatic test_status_codes();
		push_frame(4, SHAPE_CLEAN);
		push_frame(5, SHAPE_CLEAN, 8'hFF);
		push_frame(5, SHAPE_BAD_LENGTH);
		push_frame(6, SHAPE_BAD_SUM, 8'h00);
	endtask

	task automatic test_register_extremes();
		write_max(16'd4);
		push_frame(4, SHAPE_CLEAN);
		push_frame(5, SHAPE_CLEAN);
		write_max(16'd0);
		push_frame(4, SHAPE_CLEAN);
		push_frame(2, SHAPE_RAW);
		write_max(16'hFFFF);
		push_frame(8, SHAPE_CLEAN);
	endtask

	// count saturates; bytes past the limit still feed the checksum
	task automatic test_huge_frame();
		write_max(16'hFFFF);
		in_quiet = 1'b1;
		push_frame(65538, SHAPE_CLEAN);
		in_quiet = 1'b0;
	endtask

	task automatic random_frame(input int span);
		int pick;
		int n;
		in_quiet = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		n = $urandom_range(4, span);
		if (pick < 70)
			push_frame(n, SHAPE_CLEAN);
		else if (pick < 80)
			push_frame(n, SHAPE_BAD_LENGTH);
		else if (pick < 90)
			push_frame(n, SHAPE_BAD_SUM);
		else
			push_frame($urandom_range(1, span), SHAPE_RAW);
	endtask

	task automatic test_random_traffic();
		logic [15:0] settings[6];
		int          span;
		int          start;
		settings[0] = MAX_FRAME_RESET;
		settings[1] = 16'd4;
		settings[2] = 16'hFFFF;
		settings[3] = 16'($urandom_range(5, 40));
		settings[4] = 16'd0;
		settings[5] = 16'($urandom_range(8, 30));
		foreach (settings[k]) begin
			write_max(settings[k]);
			// keep frames near the limit when it is small so some run long
			span = (settings[k] <= 48) ? settings[k] + 4 : 24;
			if (span < 8)
				span = 8;
			start = n_bytes;
			while (n_bytes - start < 150)
				random_frame(($urandom_range(0, 9) == 0) ? span + 60 : span);
		end
		in_quiet = 1'b0;
	endtask

	// result side: random stall before each result is taken
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 15) == 0)
				out_quiet = !out_quiet;
			stall = out_quiet ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t %s: expected %0h, got %0h", $time, name, exp, act);
		end
	endtask

	always @(posedge clk) begin
		result_t r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, got status %0d", $time, status);
			end else begin
				r = pending_results.pop_front();
				check_field("frame_ok", 16'(r.frame_ok), 16'(frame_ok));
				check_field("status", 16'(r.status), 16'(status));
				check_field("frame_bytes", r.frame_bytes, frame_bytes);
				check_field("computed_checksum", r.computed_checksum, computed_checksum);
				n_results++;
				status_hits[r.status]++;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_status_codes();
		test_register_extremes();
		test_huge_frame();
		test_random_traffic();
		settle();
		$display("%0d frames checked from %0d bytes, over six limits and one oversized frame",
			n_results, n_bytes);
		$display("status mix: ok %0d, short %0d, long %0d, length %0d, checksum %0d",
			status_hits[ST_OK], status_hits[ST_SHORT], status_hits[ST_LONG],
			status_hits[ST_LEN], status_hits[ST_CK]);
		if (errors == 0)
			$display("frame_length_checksum_validator: match");
		else
			$display("frame_length_checksum_validator: mismatch");
		$finish;
	end

endmodule

// File: sim.f
rtl/fclv_pkg.sv
rtl/fclv_in_stage.sv
rtl/fclv_frame_core.sv
rtl/fclv_out_stage.sv
rtl/frame_length_checksum_validator.sv
tb/sv/tb.sv
